[rtl/lrp_pkg.sv]
// Shared constants, codes and types of the LR parse engine.
package lrp_pkg;

	localparam int STATE_W     = 8;
	localparam int SYM_W       = 7;
	localparam int KIND_W      = 3;
	localparam int ARG_W       = 8;
	localparam int RULE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int EVENT_W     = 3;
	localparam int LEVEL_W     = 7;
	localparam int STACK_DEPTH = 64;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int MAX_CHAIN   = 63;
	localparam int CHAIN_W     = 6;
	localparam int ACT_AW      = STATE_W + SYM_W;
	localparam int ACT_DW      = KIND_W + ARG_W;
	localparam int RULE_DW     = SYM_W + LEN_W;
	localparam int DATA_W      = 32;
	localparam int PADDR_W     = 3;

	localparam logic [2:0] OP_LOAD_ACT  = 3'd0;
	localparam logic [2:0] OP_LOAD_RULE = 3'd1;
	localparam logic [2:0] OP_START     = 3'd2;
	localparam logic [2:0] OP_TOKEN     = 3'd3;
	localparam logic [2:0] OP_END       = 3'd4;

	localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REDUCE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd3;

	localparam logic [EVENT_W-1:0] EV_REDUCE = 3'd0;
	localparam logic [EVENT_W-1:0] EV_MORE   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_ACCEPT = 3'd2;
	localparam logic [EVENT_W-1:0] EV_ERROR  = 3'd3;
	localparam logic [EVENT_W-1:0] EV_ACK    = 3'd4;

	localparam logic [1:0] ST_RUN    = 2'd0;
	localparam logic [1:0] ST_ACCEPT = 2'd1;
	localparam logic [1:0] ST_ERROR  = 2'd2;

	localparam logic [PADDR_W-1:0] REG_END_SYMBOL = 3'd0;

	typedef struct packed {
		logic               act_we;
		logic [ACT_AW-1:0]  act_addr;
		logic [ACT_DW-1:0]  act_data;
		logic               rule_we;
		logic [RULE_W-1:0]  rule_addr;
		logic [RULE_DW-1:0] rule_data;
	} tbl_wr_t;

	typedef struct packed {
		logic               act_re;
		logic [ACT_AW-1:0]  act_addr;
		logic               rule_re;
		logic [RULE_W-1:0]  rule_addr;
	} tbl_rd_t;

endpackage

[rtl/lrp_tables.sv]
// Action and rule table memories with registered read data.
module lrp_tables (
	input  logic                         clk,
	input  lrp_pkg::tbl_wr_t             wr,
	input  lrp_pkg::tbl_rd_t             rd,
	output logic [lrp_pkg::ACT_DW-1:0]   act_data,
	output logic [lrp_pkg::RULE_DW-1:0]  rule_data
);
	import lrp_pkg::*;

	logic [ACT_DW-1:0]  act_mem  [2**ACT_AW];
	logic [RULE_DW-1:0] rule_mem [2**RULE_W];

	always_ff @(posedge clk) begin
		if (wr.act_we) begin
			act_mem[wr.act_addr] <= wr.act_data;
		end
		if (rd.act_re) begin
			act_data <= act_mem[rd.act_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.rule_we) begin
			rule_mem[wr.rule_addr] <= wr.rule_data;
		end
		if (rd.rule_re) begin
			rule_data <= rule_mem[rd.rule_addr];
		end
	end

endmodule

[rtl/lr_shift_reduce_parser.sv]
// Top level of the table-driven LR parse engine.
// Load and start items give one acknowledge beat each. A token that shifts
// reads the action table, then pushes; each reduce adds a rule read, a stack
// read when the rule pops, and a goto read and push, as the table and stack
// memories have registered read data. One item is worked at a time; a pending
// result beat stalls the sequencer, and the next item is taken only once the
// token is finished.
// Tables are not cleared: entries must be loaded before they are looked up.
module lr_shift_reduce_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lrp_pkg::PADDR_W-1:0]   paddr,
	input  logic [lrp_pkg::DATA_W-1:0]    pwdata,
	output logic [lrp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [2:0]                    operation,
	input  logic [lrp_pkg::STATE_W-1:0]   table_state,
	input  logic [lrp_pkg::SYM_W-1:0]     symbol,
	input  logic [lrp_pkg::KIND_W-1:0]    action_kind,
	input  logic [lrp_pkg::ARG_W-1:0]     action_argument,
	input  logic [lrp_pkg::RULE_W-1:0]    rule_number,
	input  logic [lrp_pkg::SYM_W-1:0]     rule_head,
	input  logic [lrp_pkg::LEN_W-1:0]     rule_length,
	output logic                          event_valid,
	input  logic                          event_stall,
	output logic [lrp_pkg::EVENT_W-1:0]   event_kind,
	output logic [lrp_pkg::RULE_W-1:0]    reduced_rule,
	output logic [lrp_pkg::SYM_W-1:0]     reduced_head,
	output logic [lrp_pkg::LEVEL_W-1:0]   stack_level,
	output logic                          last
);
	import lrp_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACT  = 3'd1;
	localparam logic [2:0] S_RULE = 3'd2;
	localparam logic [2:0] S_POP  = 3'd3;
	localparam logic [2:0] S_GOTO = 3'd4;

	logic [2:0]          state_q, state_n;
	logic [LEVEL_W-1:0]  count_q, count_n;
	logic [STATE_W-1:0]  cur_q, cur_n;
	logic                open_q, open_n;
	logic [1:0]          status_q, status_n;
	logic [CHAIN_W-1:0]  chain_q, chain_n;
	logic [SYM_W-1:0]    sym_q, sym_n;
	logic [RULE_W-1:0]   rule_q, rule_n;
	logic [SYM_W-1:0]    end_sym_q;

	logic                event_valid_q;
	logic [EVENT_W-1:0]  kind_q;
	logic [RULE_W-1:0]   rrule_q;
	logic [SYM_W-1:0]    rhead_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                last_q;

	logic                emit;
	logic [EVENT_W-1:0]  em_kind;
	logic [RULE_W-1:0]   em_rule;
	logic [SYM_W-1:0]    em_head;
	logic                em_last;

	tbl_wr_t             tw;
	tbl_rd_t             tr;
	logic [ACT_DW-1:0]   act_rd;
	logic [RULE_DW-1:0]  rule_rd;

	logic [STATE_W-1:0]  stack_mem [STACK_DEPTH];
	logic [STATE_W-1:0]  stk_rd_s1;
	logic                stk_we, stk_re;
	logic [STACK_AW-1:0] stk_waddr, stk_raddr;
	logic [STATE_W-1:0]  stk_wdata;

	logic                ofree, acc;
	logic [SYM_W-1:0]    tok_sym;
	logic [KIND_W-1:0]   a_kind;
	logic [ARG_W-1:0]    a_arg;
	logic [SYM_W-1:0]    r_head;
	logic [LEN_W-1:0]    r_len;
	logic [LEVEL_W-1:0]  r_len_ext;

	lrp_tables u_tables (
		.clk       (clk),
		.wr        (tw),
		.rd        (tr),
		.act_data  (act_rd),
		.rule_data (rule_rd)
	);

	assign pready = 1'b1;
	assign prdata = (paddr == REG_END_SYMBOL) ? DATA_W'(end_sym_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_sym_q <= '0;
		end else if (psel && penable && pwrite && paddr == REG_END_SYMBOL) begin
			end_sym_q <= pwdata[SYM_W-1:0];
		end
	end

	assign ofree      = !event_valid_q || !event_stall;
	assign item_stall = (state_q != S_IDLE) || !ofree;
	assign acc        = item_valid && !item_stall;
	assign tok_sym    = (operation == OP_TOKEN) ? symbol : end_sym_q;
	assign a_kind     = act_rd[ACT_DW-1:ARG_W];
	assign a_arg      = act_rd[ARG_W-1:0];
	assign r_head     = rule_rd[RULE_DW-1:LEN_W];
	assign r_len      = rule_rd[LEN_W-1:0];
	assign r_len_ext  = LEVEL_W'(r_len);

	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		cur_n     = cur_q;
		open_n    = open_q;
		status_n  = status_q;
		chain_n   = chain_q;
		sym_n     = sym_q;
		rule_n    = rule_q;
		emit      = 1'b0;
		em_kind   = EV_ACK;
		em_rule   = '0;
		em_head   = '0;
		em_last   = 1'b1;
		tw        = '0;
		tr        = '0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_waddr = count_q[STACK_AW-1:0];
		stk_raddr = '0;
		stk_wdata = cur_q;

		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (operation) inside
						OP_LOAD_ACT: begin
							tw.act_we   = 1'b1;
							tw.act_addr = {table_state, symbol};
							tw.act_data = {action_kind, action_argument};
							emit        = 1'b1;
						end
						OP_LOAD_RULE: begin
							tw.rule_we   = 1'b1;
							tw.rule_addr = rule_number;
							tw.rule_data = {rule_head, rule_length};
							emit         = 1'b1;
						end
						OP_START: begin
							count_n  = '0;
							cur_n    = '0;
							open_n   = 1'b1;
							status_n = ST_RUN;
							emit     = 1'b1;
						end
						OP_TOKEN, OP_END: begin
							emit = 1'b1;
							if (!open_q || status_q == ST_ERROR) begin
								em_kind = EV_ERROR;
							end else if (status_q == ST_ACCEPT) begin
								em_kind = EV_ACCEPT;
							end else begin
								emit        = 1'b0;
								sym_n       = tok_sym;
								chain_n     = '0;
								tr.act_re   = 1'b1;
								tr.act_addr = {cur_q, tok_sym};
								state_n     = S_ACT;
							end
						end
						default: ;
					endcase
				end
			end
			S_ACT: begin
				if (ofree) begin
					state_n = S_IDLE;
					emit    = 1'b1;
					em_kind = EV_ERROR;
					case (a_kind) inside
						KIND_SHIFT, KIND_GOTO: begin
							if (count_q == LEVEL_W'(STACK_DEPTH)) begin
								status_n = ST_ERROR;
							end else begin
								stk_we  = 1'b1;
								count_n = count_q + 1'b1;
								cur_n   = a_arg;
								em_kind = EV_MORE;
							end
						end
						KIND_REDUCE: begin
							if (chain_q == CHAIN_W'(MAX_CHAIN)) begin
								status_n = ST_ERROR;
							end else begin
								emit         = 1'b0;
								chain_n      = chain_q + 1'b1;
								rule_n       = a_arg;
								tr.rule_re   = 1'b1;
								tr.rule_addr = a_arg;
								state_n      = S_RULE;
							end
						end
						KIND_ACCEPT: begin
							status_n = ST_ACCEPT;
							em_kind  = EV_ACCEPT;
						end
						default: status_n = ST_ERROR;
					endcase
				end
			end
			S_RULE: begin
				if (ofree) begin
					if (r_len_ext > count_q) begin
						status_n = ST_ERROR;
						emit     = 1'b1;
						em_kind  = EV_ERROR;
						state_n  = S_IDLE;
					end else if (r_len != '0) begin
						count_n   = count_q - r_len_ext;
						stk_re    = 1'b1;
						stk_raddr = count_n[STACK_AW-1:0];
						state_n   = S_POP;
					end else begin
						emit        = 1'b1;
						em_kind     = EV_REDUCE;
						em_rule     = rule_q;
						em_head     = r_head;
						em_last     = 1'b0;
						tr.act_re   = 1'b1;
						tr.act_addr = {cur_q, r_head};
						state_n     = S_GOTO;
					end
				end
			end
			S_POP: begin
				if (ofree) begin
					cur_n       = stk_rd_s1;
					emit        = 1'b1;
					em_kind     = EV_REDUCE;
					em_rule     = rule_q;
					em_head     = r_head;
					em_last     = 1'b0;
					tr.act_re   = 1'b1;
					tr.act_addr = {stk_rd_s1, r_head};
					state_n     = S_GOTO;
				end
			end
			S_GOTO: begin
				if (ofree) begin
					if ((a_kind == KIND_SHIFT || a_kind == KIND_GOTO)
						&& count_q != LEVEL_W'(STACK_DEPTH)) begin
						stk_we      = 1'b1;
						count_n     = count_q + 1'b1;
						cur_n       = a_arg;
						tr.act_re   = 1'b1;
						tr.act_addr = {a_arg, sym_q};
						state_n     = S_ACT;
					end else begin
						status_n = ST_ERROR;
						emit     = 1'b1;
						em_kind  = EV_ERROR;
						state_n  = S_IDLE;
					end
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// stack memory: push writes at the old level, pop reads the new top
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_s1 <= stack_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cur_q    <= '0;
			open_q   <= 1'b0;
			status_q <= ST_RUN;
			chain_q  <= '0;
		end else begin
			state_q  <= state_n;
			count_q  <= count_n;
			cur_q    <= cur_n;
			open_q   <= open_n;
			status_q <= status_n;
			chain_q  <= chain_n;
		end
	end

	always_ff @(posedge clk) begin
		sym_q  <= sym_n;
		rule_q <= rule_n;
	end

	// output register: load a beat when emitted, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_q <= 1'b0;
		end else if (emit) begin
			event_valid_q <= 1'b1;
		end else if (!event_stall) begin
			event_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= em_kind;
			rrule_q <= em_rule;
			rhead_q <= em_head;
			level_q <= count_n;
			last_q  <= em_last;
		end
	end

	assign event_valid  = event_valid_q;
	assign event_kind   = kind_q;
	assign reduced_rule = rrule_q;
	assign reduced_head = rhead_q;
	assign stack_level  = level_q;
	assign last         = last_q;

endmodule

[sim/lr_parse_checker.sv]
// Event predictor and scoreboard for the LR parse engine.
module lr_parse_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [lrp_pkg::PADDR_W-1:0]  paddr,
	input  logic [lrp_pkg::DATA_W-1:0]   pwdata,
	input  logic                         item_valid,
	input  logic                         item_stall,
	input  logic [2:0]                   operation,
	input  logic [lrp_pkg::STATE_W-1:0]  table_state,
	input  logic [lrp_pkg::SYM_W-1:0]    symbol,
	input  logic [lrp_pkg::KIND_W-1:0]   action_kind,
	input  logic [lrp_pkg::ARG_W-1:0]    action_argument,
	input  logic [lrp_pkg::RULE_W-1:0]   rule_number,
	input  logic [lrp_pkg::SYM_W-1:0]    rule_head,
	input  logic [lrp_pkg::LEN_W-1:0]    rule_length,
	input  logic                         event_valid,
	input  logic                         event_stall,
	input  logic [lrp_pkg::EVENT_W-1:0]  event_kind,
	input  logic [lrp_pkg::RULE_W-1:0]   reduced_rule,
	input  logic [lrp_pkg::SYM_W-1:0]    reduced_head,
	input  logic [lrp_pkg::LEVEL_W-1:0]  stack_level,
	input  logic                         last,
	output int                           fail_count,
	output int                           pending
);
	import lrp_pkg::*;

	typedef struct packed {
		logic [EVENT_W-1:0] kind;
		logic [RULE_W-1:0]  rule;
		logic [SYM_W-1:0]   head;
		logic [LEVEL_W-1:0] level;
		logic               fin;
	} parse_event_t;

	parse_event_t        event_q[$];
	logic [ACT_DW-1:0]   act_mem [0:(1<<ACT_AW)-1];
	logic [RULE_DW-1:0]  rule_mem[0:(1<<RULE_W)-1];
	logic [STATE_W-1:0]  state_stk[0:STACK_DEPTH-1];
	int                  depth;
	logic [STATE_W-1:0]  cur_state;
	logic                parse_open;
	logic [1:0]          status;
	logic [SYM_W-1:0]    end_sym;

	assign pending = event_q.size();

	task automatic post(input logic [EVENT_W-1:0] k, input logic [RULE_W-1:0] r,
			input logic [SYM_W-1:0] h, input logic f);
		parse_event_t e;
		e.kind = k;
		e.rule = r;
		e.head = h;
		e.level = depth[LEVEL_W-1:0];
		e.fin = f;
		event_q = {event_q, e};
	endtask

	task automatic flag_error();
		status = ST_ERROR;
		post(EV_ERROR, '0, '0, 1'b1);
	endtask

	function automatic bit push_state(input logic [STATE_W-1:0] target);
		if (depth >= STACK_DEPTH)
			return 1'b0;
		state_stk[depth] = cur_state;
		depth++;
		cur_state = target;
		return 1'b1;
	endfunction

	task automatic work_token(input logic [SYM_W-1:0] sym);
		int                 chain;
		logic [ACT_DW-1:0]  entry;
		logic [ACT_DW-1:0]  go;
		logic [RULE_DW-1:0] rule;
		logic [SYM_W-1:0]   head;
		int                 len;
		chain = 0;
		if (!parse_open || status == ST_ERROR) begin
			post(EV_ERROR, '0, '0, 1'b1);
			return;
		end
		if (status == ST_ACCEPT) begin
			post(EV_ACCEPT, '0, '0, 1'b1);
			return;
		end
		forever begin
			entry = act_mem[{cur_state, sym}];
			if (entry[10:8] == KIND_SHIFT || entry[10:8] == KIND_GOTO) begin
				if (!push_state(entry[7:0]))
					flag_error();
				else
					post(EV_MORE, '0, '0, 1'b1);
				return;
			end else if (entry[10:8] == KIND_REDUCE) begin
				if (chain >= MAX_CHAIN) begin
					flag_error();
					return;
				end
				chain++;
				rule = rule_mem[entry[7:0]];
				head = rule[10:4];
				len = rule[3:0];
				if (len > depth) begin
					flag_error();
					return;
				end
				if (len > 0) begin
					depth -= len;
					cur_state = state_stk[depth];
				end
				post(EV_REDUCE, entry[7:0], head, 1'b0);
				go = act_mem[{cur_state, head}];
				if (!(go[10:8] == KIND_SHIFT || go[10:8] == KIND_GOTO) ||
						!push_state(go[7:0])) begin
					flag_error();
					return;
				end
			end else if (entry[10:8] == KIND_ACCEPT) begin
				status = ST_ACCEPT;
				post(EV_ACCEPT, '0, '0, 1'b1);
				return;
			end else begin
				flag_error();
				return;
			end
		end
	endtask

	task automatic predict_item();
		case (operation)
			OP_LOAD_ACT: begin
				act_mem[{table_state, symbol}] = {action_kind, action_argument};
				post(EV_ACK, '0, '0, 1'b1);
			end
			OP_LOAD_RULE: begin
				rule_mem[rule_number] = {rule_head, rule_length};
				post(EV_ACK, '0, '0, 1'b1);
			end
			OP_START: begin
				depth = 0;
				cur_state = '0;
				parse_open = 1'b1;
				status = ST_RUN;
				post(EV_ACK, '0, '0, 1'b1);
			end
			OP_TOKEN: work_token(symbol);
			OP_END:   work_token(end_sym);
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		parse_event_t want;
		if (!arst_n) begin
			event_q.delete();
			depth = 0;
			cur_state = '0;
			parse_open = 1'b0;
			status = ST_RUN;
			end_sym = '0;
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_END_SYMBOL)
				end_sym = pwdata[SYM_W-1:0];
			if (item_valid && !item_stall)
				predict_item();
			if (event_valid && !event_stall) begin
				if (event_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected event beat: kind %0d rule %0d head %0d %s",
							event_kind, reduced_rule, reduced_head,
							$sformatf("level %0d last %0d", stack_level, last));
				end else begin
					want = event_q.pop_front();
					if (want.kind !== event_kind || want.rule !== reduced_rule ||
							want.head !== reduced_head || want.level !== stack_level ||
							want.fin !== last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("event mismatch: expected kind %0d rule %0d head %0d %s",
								want.kind, want.rule, want.head,
								$sformatf("level %0d last %0d", want.level, want.fin));
							$display("                got kind %0d rule %0d head %0d %s",
								event_kind, reduced_rule, reduced_head,
								$sformatf("level %0d last %0d", stack_level, last));
						end
					end
				end
			end
		end
	end

endmodule

[sim/lr_shift_reduce_parser_test.sv]
// Stimulus and verdict for the LR parse engine.
module lr_shift_reduce_parser_test;
	import lrp_pkg::*;

	localparam logic [2:0]        OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0]        OP_LAST_UNUSED  = 3'd7;
	localparam logic [KIND_W-1:0] KIND_ERROR      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TOP        = 3'd7;
	localparam int                CYCLE_LIMIT     = 1000000;
	localparam int                LONG_HOLD       = 300;

	typedef struct {
		logic [2:0]         op;
		logic [STATE_W-1:0] st;
		logic [SYM_W-1:0]   sym;
		logic [KIND_W-1:0]  kind;
		logic [ARG_W-1:0]   arg;
		logic [RULE_W-1:0]  rnum;
		logic [SYM_W-1:0]   rhead;
		logic [LEN_W-1:0]   rlen;
	} parse_item_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic pready;
	logic item_valid = 0;
	logic item_stall;
	logic [2:0]         operation = '0;
	logic [STATE_W-1:0] table_state = '0;
	logic [SYM_W-1:0]   symbol = '0;
	logic [KIND_W-1:0]  action_kind = '0;
	logic [ARG_W-1:0]   action_argument = '0;
	logic [RULE_W-1:0]  rule_number = '0;
	logic [SYM_W-1:0]   rule_head = '0;
	logic [LEN_W-1:0]   rule_length = '0;
	logic event_valid;
	logic event_stall = 1;
	logic [EVENT_W-1:0] event_kind;
	logic [RULE_W-1:0]  reduced_rule;
	logic [SYM_W-1:0]   reduced_head;
	logic [LEVEL_W-1:0] stack_level;
	logic last;
	int fail_count, pending;

	// lookups stay inside these states, symbols and rules, all loaded first
	int live_states[6] = '{0, 1, 2, 3, 254, 255};
	int live_syms[6]   = '{0, 1, 2, 3, 126, 127};
	int live_rules[5]  = '{0, 1, 2, 3, 255};
	int end_choices[3] = '{0, 126, 127};
	bit burst = 0;
	bit hold_req = 0;
	parse_item_t it;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	lr_shift_reduce_parser DUT (.*);

	lr_parse_checker scoreboard (.*);

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("lr_shift_reduce_parser verification failed");
		$finish;
	end

	// event side: random stall per beat, one long hold on request
	initial begin
		int n;
		@(posedge clk iff arst_n);
		forever begin
			n = burst ? 0 : $urandom_range(0, 13);
			if (hold_req) begin
				n = LONG_HOLD;
				hold_req = 0;
			end
			repeat (n) begin
				event_stall <= 1;
				@(posedge clk);
			end
			event_stall <= 0;
			do @(posedge clk); while (!(event_valid && !event_stall));
		end
	end

	task automatic scramble();
		it.op = OP_TOKEN;
		it.st = STATE_W'($urandom);
		it.sym = SYM_W'($urandom);
		it.kind = KIND_W'($urandom);
		it.arg = ARG_W'($urandom);
		it.rnum = RULE_W'($urandom);
		it.rhead = SYM_W'($urandom);
		it.rlen = LEN_W'($urandom);
	endtask

	task automatic send();
		int g;
		g = burst ? 0 : $urandom_range(0, 13);
		if (g > 0) begin
			item_valid <= 0;
			repeat (g) @(posedge clk);
		end
		item_valid <= 1;
		operation <= it.op;
		table_state <= it.st;
		symbol <= it.sym;
		action_kind <= it.kind;
		action_argument <= it.arg;
		rule_number <= it.rnum;
		rule_head <= it.rhead;
		rule_length <= it.rlen;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic load_action(input int st, input int sym, input logic [KIND_W-1:0] k,
			input int arg);
		scramble();
		it.op = OP_LOAD_ACT;
		it.st = STATE_W'(st);
		it.sym = SYM_W'(sym);
		it.kind = k;
		it.arg = ARG_W'(arg);
		send();
	endtask

	task automatic load_rule(input int r, input int head, input int len);
		scramble();
		it.op = OP_LOAD_RULE;
		it.rnum = RULE_W'(r);
		it.rhead = SYM_W'(head);
		it.rlen = LEN_W'(len);
		send();
	endtask

	task automatic send_op(input logic [2:0] op, input int sym);
		scramble();
		it.op = op;
		it.sym = SYM_W'(sym);
		send();
	endtask

	task automatic drain();
		item_valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_end_symbol(input int value);
		psel <= 1;
		pwrite <= 1;
		paddr <= REG_END_SYMBOL;
		pwdata <= DATA_W'(value);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic build_tables();
		int w;
		logic [KIND_W-1:0] k;
		int arg;
		foreach (live_rules[r])
			load_rule(live_rules[r], live_syms[$urandom_range(0, 5)],
				($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 3));
		foreach (live_states[s])
			foreach (live_syms[y]) begin
				w = $urandom_range(0, 99);
				arg = live_states[$urandom_range(0, 5)];
				if (w < 40)
					k = KIND_SHIFT;
				else if (w < 50)
					k = KIND_GOTO;
				else if (w < 80) begin
					k = KIND_REDUCE;
					arg = live_rules[$urandom_range(0, 4)];
				end else if (w < 88)
					k = KIND_ACCEPT;
				else
					k = KIND_W'($urandom_range(KIND_ERROR, KIND_TOP));
				load_action(live_states[s], live_syms[y], k, arg);
			end
	endtask

	task automatic random_parses(input int count);
		int n;
		int w;
		n = 0;
		while (n < count) begin
			send_op(OP_START, 0);
			n++;
			repeat ($urandom_range(1, 10)) begin
				w = $urandom_range(0, 99);
				if (w < 4)
					send_op(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), 0);
				else if (w < 8)
					load_action($urandom_range(6, 253), $urandom, KIND_W'($urandom),
						$urandom);
				else
					send_op(OP_TOKEN, live_syms[$urandom_range(0, 5)]);
				n++;
			end
			send_op(OP_END, 0);
			n++;
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_end_symbol(127);

		// directed: before start, unused codes, extremes and the error paths
		send_op(OP_TOKEN, 0);
		send_op(OP_END, 0);
		for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
			send_op(3'(op), 0);
		load_action(255, 127, KIND_TOP, 255);
		load_rule(255, 127, 15);
		load_action(0, 5, KIND_REDUCE, 7);
		load_rule(7, 6, 0);
		load_action(0, 6, KIND_GOTO, 0);
		load_action(0, 4, KIND_SHIFT, 0);
		load_action(0, 127, KIND_ACCEPT, 0);
		load_rule(9, 6, 15);
		load_action(0, 9, KIND_REDUCE, 9);
		load_rule(10, 127, 0);
		load_action(0, 11, KIND_REDUCE, 10);
		// reduction chain runs out
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 5);
		send_op(OP_TOKEN, 4);
		// stack overflow inside a chain
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 4);
		send_op(OP_TOKEN, 4);
		send_op(OP_TOKEN, 5);
		// accept at end of input, then sticky
		send_op(OP_START, 0);
		send_op(OP_END, 0);
		send_op(OP_TOKEN, 4);
		// underflow, then bad goto
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 9);
		send_op(OP_START, 0);
		send_op(OP_TOKEN, 11);
		drain();

		foreach (end_choices[p]) begin
			write_end_symbol(end_choices[p]);
			burst = (p == 1);
			build_tables();
			if (p == 0)
				hold_req = 1;
			random_parses(8);
			if (p == 2) begin
				// pause the sender until every event is out
				item_valid <= 0;
				@(posedge clk);
				wait (pending == 0);
			end
			random_parses(8);
			burst = 0;
			drain();
		end

		repeat (30) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("lr_shift_reduce_parser verification clean");
		else
			$display("lr_shift_reduce_parser verification failed");
		$finish;
	end

endmodule
